// ===== hw/rtl/bdas_pkg.sv =====
`default_nettype none

package bdas_pkg;

  localparam int T_FRAC_BITS = 10;
  localparam int IMAGE_SIZE  = 700;
  localparam int COORD_W     = 10;
  localparam int NUM_PTS     = 4;
  localparam int NUM_PIX     = 4;
  localparam int NUM_REGS    = 2 * NUM_PTS;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int TW          = T_FRAC_BITS + 1;
  localparam int PT_W        = COORD_W + T_FRAC_BITS;
  localparam int PROD_W      = PT_W + TW;
  localparam int MAG_W       = T_FRAC_BITS + 2;
  localparam int SQ_W        = 2 * MAG_W;
  localparam int SUM_W       = SQ_W + 1;
  localparam int K_SHIFT     = 2 * T_FRAC_BITS - 3;
  localparam int K_W         = SUM_W - K_SHIFT;
  localparam int W_W         = 8;
  localparam int GAUSS_N     = 89;
  localparam int GI_W        = $clog2(GAUSS_N);

  localparam logic [TW-1:0] T_ONE = TW'(1) << T_FRAC_BITS;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_P0_X,
    REG_P0_Y,
    REG_P1_X,
    REG_P1_Y,
    REG_P2_X,
    REG_P2_Y,
    REG_P3_X,
    REG_P3_Y
  } cfg_reg_e;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } point_t;

  typedef point_t [NUM_PTS-1:0] ctrl_pts_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [W_W-1:0]     w;
  } pix_t;

  typedef struct packed {
    logic [NUM_PIX-1:0]       vld;
    pix_t [NUM_PIX-1:0]       pix;
  } splat_t;

  // floor(255*exp(-k/16))
  localparam logic [W_W-1:0] GAUSS_TAB [GAUSS_N] = '{
    8'd255, 8'd239, 8'd225, 8'd211, 8'd198, 8'd186, 8'd175, 8'd164,
    8'd154, 8'd145, 8'd136, 8'd128, 8'd120, 8'd113, 8'd106, 8'd99,
    8'd93,  8'd88,  8'd82,  8'd77,  8'd73,  8'd68,  8'd64,  8'd60,
    8'd56,  8'd53,  8'd50,  8'd47,  8'd44,  8'd41,  8'd39,  8'd36,
    8'd34,  8'd32,  8'd30,  8'd28,  8'd26,  8'd25,  8'd23,  8'd22,
    8'd20,  8'd19,  8'd18,  8'd17,  8'd16,  8'd15,  8'd14,  8'd13,
    8'd12,  8'd11,  8'd11,  8'd10,  8'd9,   8'd9,   8'd8,   8'd8,
    8'd7,   8'd7,   8'd6,   8'd6,   8'd5,   8'd5,   8'd5,   8'd4,
    8'd4,   8'd4,   8'd4,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
    8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd1,   8'd1,
    8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
    8'd1
  };

  function automatic logic [W_W-1:0] gauss_weight(input logic [K_W-1:0] k);
    logic [W_W-1:0] w;
    w = '0;
    if (k < K_W'(GAUSS_N)) begin
      w = GAUSS_TAB[k[GI_W-1:0]];
    end
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/bdas_front.sv =====
`default_nettype none

module bdas_front import bdas_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_pts_t         cp_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [TW-1:0]     t_step_i,
  output logic              item_valid_o,
  input  logic              item_ready_i,
  output splat_t            item_o
);

  localparam int NSTG = 9;
  localparam logic [PROD_W-1:0] HALF    = PROD_W'(1) << (T_FRAC_BITS - 1);
  localparam logic [MAG_W-1:0]  ONE_M   = MAG_W'(1) << T_FRAC_BITS;
  localparam logic [MAG_W-1:0]  THREE_M = MAG_W'(3) << T_FRAC_BITS;
  localparam logic [SUM_W-1:0]  K_BIAS  = SUM_W'(1) << (2 * T_FRAC_BITS - 4);
  localparam logic [COORD_W:0]  LIMIT   = (COORD_W + 1)'(IMAGE_SIZE);

  function automatic logic [PT_W-1:0] lerp_sum(input logic [PROD_W-1:0] pa,
                                                input logic [PROD_W-1:0] pb);
    logic [PROD_W-1:0] s;
    s = pa + pb + HALF;
    return s[T_FRAC_BITS +: PT_W];
  endfunction

  logic [NSTG-1:0]    v_q;
  logic               en;
  logic [TW-1:0]      t_c;
  logic [TW-1:0]      t_q [5];

  logic [PT_W-1:0]    lv0 [2][4];
  logic [PROD_W-1:0]  pa1_q [2][3];
  logic [PROD_W-1:0]  pb1_q [2][3];
  logic [PT_W-1:0]    lv1_q [2][3];
  logic [PROD_W-1:0]  pa2_q [2][2];
  logic [PROD_W-1:0]  pb2_q [2][2];
  logic [PT_W-1:0]    lv2_q [2][2];
  logic [PROD_W-1:0]  pa3_q [2];
  logic [PROD_W-1:0]  pb3_q [2];
  logic [PT_W-1:0]    lv3_q [2];

  logic [SQ_W-1:0]    sq_d [2][2];
  logic [SQ_W-1:0]    sq_q [2][2];
  logic [COORD_W-1:0] base_q [2];
  logic [NUM_PIX-1:0] mask_d, mask_q;
  splat_t             item_d, item_q;

  assign t_c = (t_step_i > T_ONE) ? T_ONE : t_step_i;

  assign item_o       = item_q;
  assign item_valid_o = v_q[NSTG-1] && (|item_q.vld);
  assign en           = !(item_valid_o && !item_ready_i);
  assign in_ready_o   = en;

  always_comb begin
    for (int i = 0; i < NUM_PTS; i++) begin
      lv0[0][i] = {cp_i[i].x, {T_FRAC_BITS{1'b0}}};
      lv0[1][i] = {cp_i[i].y, {T_FRAC_BITS{1'b0}}};
    end
  end

  // offsets from both pixel centres, squared
  always_comb begin
    logic [MAG_W-1:0] two_f;
    logic [MAG_W-1:0] m0;
    logic [MAG_W-1:0] m1;
    for (int ax = 0; ax < 2; ax++) begin
      two_f = {1'b0, lv3_q[ax][T_FRAC_BITS-1:0], 1'b0};
      m0 = (two_f >= ONE_M) ? two_f - ONE_M : ONE_M - two_f;
      m1 = THREE_M - two_f;
      sq_d[ax][0] = SQ_W'(m0) * SQ_W'(m0);
      sq_d[ax][1] = SQ_W'(m1) * SQ_W'(m1);
    end
  end

  always_comb begin
    logic [COORD_W:0] cx;
    logic [COORD_W:0] cy;
    for (int dx = 0; dx < 2; dx++) begin
      for (int dy = 0; dy < 2; dy++) begin
        cx = {1'b0, lv3_q[0][T_FRAC_BITS +: COORD_W]} + (COORD_W + 1)'(dx);
        cy = {1'b0, lv3_q[1][T_FRAC_BITS +: COORD_W]} + (COORD_W + 1)'(dy);
        mask_d[2 * dx + dy] = (cx < LIMIT) && (cy < LIMIT);
      end
    end
  end

  always_comb begin
    logic [SUM_W-1:0] s;
    item_d.vld = mask_q;
    for (int dx = 0; dx < 2; dx++) begin
      for (int dy = 0; dy < 2; dy++) begin
        s = SUM_W'(sq_q[0][dx]) + SUM_W'(sq_q[1][dy]) + K_BIAS;
        item_d.pix[2 * dx + dy].x = base_q[0] + COORD_W'(dx);
        item_d.pix[2 * dx + dy].y = base_q[1] + COORD_W'(dy);
        item_d.pix[2 * dx + dy].w = gauss_weight(s[K_SHIFT +: K_W]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t_q[0] <= t_c;
      for (int s = 1; s < 5; s++) begin
        t_q[s] <= t_q[s-1];
      end
      for (int ax = 0; ax < 2; ax++) begin
        for (int i = 0; i < 3; i++) begin
          pa1_q[ax][i] <= PROD_W'(lv0[ax][i])   * PROD_W'(T_ONE - t_q[0]);
          pb1_q[ax][i] <= PROD_W'(lv0[ax][i+1]) * PROD_W'(t_q[0]);
          lv1_q[ax][i] <= lerp_sum(pa1_q[ax][i], pb1_q[ax][i]);
        end
        for (int i = 0; i < 2; i++) begin
          pa2_q[ax][i] <= PROD_W'(lv1_q[ax][i])   * PROD_W'(T_ONE - t_q[2]);
          pb2_q[ax][i] <= PROD_W'(lv1_q[ax][i+1]) * PROD_W'(t_q[2]);
          lv2_q[ax][i] <= lerp_sum(pa2_q[ax][i], pb2_q[ax][i]);
        end
        pa3_q[ax]  <= PROD_W'(lv2_q[ax][0]) * PROD_W'(T_ONE - t_q[4]);
        pb3_q[ax]  <= PROD_W'(lv2_q[ax][1]) * PROD_W'(t_q[4]);
        lv3_q[ax]  <= lerp_sum(pa3_q[ax], pb3_q[ax]);
        base_q[ax] <= lv3_q[ax][T_FRAC_BITS +: COORD_W];
        sq_q[ax]   <= sq_d[ax];
      end
      mask_q <= mask_d;
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bdas_fifo.sv =====
`default_nettype none

module bdas_fifo import bdas_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   in_valid_i,
  output logic   in_ready_o,
  input  splat_t in_i,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output splat_t out_o
);

  localparam int QD = 2;
  localparam int PW = $clog2(QD);
  localparam int CW = $clog2(QD + 1);

  splat_t          mem_q [QD];
  logic [PW-1:0]   wp_q, rp_q;
  logic [CW-1:0]   cnt_q;
  logic            push, pop;

  assign in_ready_o  = (cnt_q != CW'(QD));
  assign out_valid_o = (cnt_q != '0);
  assign out_o       = mem_q[rp_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wp_q <= wp_q + PW'(1);
      end
      if (pop) begin
        rp_q <= rp_q + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   cnt_q <= cnt_q + CW'(1);
        2'b01:   cnt_q <= cnt_q - CW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wp_q] <= in_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bdas_back.sv =====
`default_nettype none

module bdas_back import bdas_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  output logic               item_ready_o,
  input  splat_t             item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [COORD_W-1:0] pix_x_o,
  output logic [COORD_W-1:0] pix_y_o,
  output logic [W_W-1:0]     green_add_o,
  output logic               last_o
);

  splat_t             cur_q;
  logic [NUM_PIX-1:0] rem_q, rem_nx, sel_oh;
  logic [1:0]         sel;
  logic               busy, adv, pop;
  logic               out_v_q;
  pix_t               out_q;
  logic               last_q;

  always_comb begin
    priority if (rem_q[0]) begin
      sel = 2'd0;
    end else if (rem_q[1]) begin
      sel = 2'd1;
    end else if (rem_q[2]) begin
      sel = 2'd2;
    end else begin
      sel = 2'd3;
    end
  end

  assign sel_oh       = NUM_PIX'(1) << sel;
  assign rem_nx       = rem_q & ~sel_oh;
  assign busy         = |rem_q;
  assign adv          = busy && (!out_v_q || out_ready_i);
  assign item_ready_o = !busy || (adv && (rem_nx == '0));
  assign pop          = item_valid_i && item_ready_o;

  assign out_valid_o = out_v_q;
  assign pix_x_o     = out_q.x;
  assign pix_y_o     = out_q.y;
  assign green_add_o = out_q.w;
  assign last_o      = last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      if (pop) begin
        rem_q <= item_i.vld;
      end else if (adv) begin
        rem_q <= rem_nx;
      end
      if (adv) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= item_i;
    end
    if (adv) begin
      out_q  <= cur_q.pix[sel];
      last_q <= (rem_nx == '0);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/bezier_decasteljau_antialias_splat_top.sv =====
// Throughput: a new t every cycle into a 9-stage front pipe, unless stalled by back-pressure;
// the single result port then sends 0..4 beats per t, and that port's back-pressure stalls the pipe.
// A t with no pixel inside the image yields no beat.
// Reset (rst_ni, async, active low) clears control points to 0 and empties all stages.
`default_nettype none

module bezier_decasteljau_antialias_splat_top import bdas_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [TW-1:0]        t_step_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [COORD_W-1:0]   pix_x_o,
  output logic [COORD_W-1:0]   pix_y_o,
  output logic [W_W-1:0]       green_add_o,
  output logic                 last_o
);

  ctrl_pts_t cp_q;
  logic      q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  splat_t    q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_P0_X: cp_q[0].x <= cfg_data_i;
        REG_P0_Y: cp_q[0].y <= cfg_data_i;
        REG_P1_X: cp_q[1].x <= cfg_data_i;
        REG_P1_Y: cp_q[1].y <= cfg_data_i;
        REG_P2_X: cp_q[2].x <= cfg_data_i;
        REG_P2_Y: cp_q[2].y <= cfg_data_i;
        REG_P3_X: cp_q[3].x <= cfg_data_i;
        REG_P3_Y: cp_q[3].y <= cfg_data_i;
        default:  cp_q      <= cp_q;
      endcase
    end
  end

  bdas_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cp_i         (cp_q),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .t_step_i     (t_step_i),
    .item_valid_o (q_in_valid),
    .item_ready_i (q_in_ready),
    .item_o       (q_in)
  );

  bdas_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_in_valid),
    .in_ready_o  (q_in_ready),
    .in_i        (q_in),
    .out_valid_o (q_out_valid),
    .out_ready_i (q_out_ready),
    .out_o       (q_out)
  );

  bdas_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_out_valid),
    .item_ready_o (q_out_ready),
    .item_i       (q_out),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .pix_x_o      (pix_x_o),
    .pix_y_o      (pix_y_o),
    .green_add_o  (green_add_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/bdas_checker.sv =====
`default_nettype none

module bdas_checker import bdas_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 cfg_we_i,
  input logic [REG_IDX_W-1:0] cfg_idx_i,
  input logic [COORD_W-1:0]   cfg_data_i,
  input logic                 in_valid_i,
  input logic                 in_ready_o,
  input logic [TW-1:0]        t_step_i,
  input logic                 out_valid_o,
  input logic                 out_ready_i,
  input logic [COORD_W-1:0]   pix_x_o,
  input logic [COORD_W-1:0]   pix_y_o,
  input logic [W_W-1:0]       green_add_o,
  input logic                 last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped before taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(pix_x_o) && $stable(pix_y_o)
                                    && $stable(green_add_o) && $stable(last_o))
    else $error("stalled result beat changed");

  a_in_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pix_x_o < COORD_W'(IMAGE_SIZE)) && (pix_y_o < COORD_W'(IMAGE_SIZE)))
    else $error("pixel outside image emitted");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |-> !out_valid_o)
    else $error("result valid during reset");

endmodule

bind bezier_decasteljau_antialias_splat_top bdas_checker u_bdas_checker (.*);

`default_nettype wire

// ===== sim/splat_check.sv =====
`timescale 1ns / 100ps

module splat_check import bdas_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [REG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_data_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic [TW-1:0]        t_step_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  logic [COORD_W-1:0]   pix_x_i,
  input  logic [COORD_W-1:0]   pix_y_i,
  input  logic [W_W-1:0]       green_add_i,
  input  logic                 last_i,
  output int                   errors_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [W_W-1:0]     w;
    logic               last;
  } splat_beat_t;

  logic [COORD_W-1:0] ctrl_x [NUM_PTS];
  logic [COORD_W-1:0] ctrl_y [NUM_PTS];
  logic [W_W-1:0]     falloff [GAUSS_N];
  splat_beat_t        splat_q [$];
  int                 mismatches;

  // floor(255*exp(-k/16))
  initial begin
    for (int k = 0; k < GAUSS_N; k++) begin
      falloff[k] = W_W'($rtoi($floor(255.0 * $exp(-k / 16.0))));
    end
  end

  function automatic longint unsigned blend(longint unsigned a, longint unsigned b,
                                            longint unsigned t);
    return (a * ((64'd1 << T_FRAC_BITS) - t) + b * t + (64'd1 << (T_FRAC_BITS - 1)))
           >> T_FRAC_BITS;
  endfunction

  function automatic longint unsigned curve_coord(bit axis_y, longint unsigned t);
    longint unsigned lvl [NUM_PTS];
    for (int i = 0; i < NUM_PTS; i++) begin
      lvl[i] = axis_y ? ctrl_y[i] : ctrl_x[i];
      lvl[i] = lvl[i] << T_FRAC_BITS;
    end
    for (int n = NUM_PTS - 1; n > 0; n--) begin
      for (int i = 0; i < n; i++) begin
        lvl[i] = blend(lvl[i], lvl[i + 1], t);
      end
    end
    return lvl[0];
  endfunction

  // squared offset from the pixel centre, in units of 2^-(2T+2)
  function automatic longint unsigned centre_dist_sq(longint unsigned frac, int d);
    longint u;
    u = frac;
    u = 2 * u - (2 * d + 1) * (1 << T_FRAC_BITS);
    return u * u;
  endfunction

  function automatic void predict_splat(logic [TW-1:0] t_raw);
    longint unsigned t, px, py, fx, fy, cx, cy, k, frac_mask;
    splat_beat_t     hits [NUM_PIX];
    int              n;
    frac_mask = (64'd1 << T_FRAC_BITS) - 1;
    t = t_raw;
    if (t > T_ONE) begin
      t = T_ONE;
    end
    px = curve_coord(1'b0, t);
    py = curve_coord(1'b1, t);
    fx = px & frac_mask;
    fy = py & frac_mask;
    n = 0;
    for (int dx = 0; dx < 2; dx++) begin
      for (int dy = 0; dy < 2; dy++) begin
        cx = (px >> T_FRAC_BITS) + dx;
        cy = (py >> T_FRAC_BITS) + dy;
        if (cx < IMAGE_SIZE && cy < IMAGE_SIZE) begin
          k = (centre_dist_sq(fx, dx) + centre_dist_sq(fy, dy)
               + (64'd1 << (2 * T_FRAC_BITS - 4))) >> K_SHIFT;
          hits[n].x    = cx[COORD_W-1:0];
          hits[n].y    = cy[COORD_W-1:0];
          hits[n].w    = (k < GAUSS_N) ? falloff[k] : '0;
          hits[n].last = 1'b0;
          n++;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      hits[i].last = (i == n - 1);
      splat_q.insert(splat_q.size(), hits[i]);
    end
  endfunction

  function automatic void store_reg(cfg_reg_e idx, logic [COORD_W-1:0] val);
    case (idx)
      REG_P0_X: ctrl_x[0] = val;
      REG_P0_Y: ctrl_y[0] = val;
      REG_P1_X: ctrl_x[1] = val;
      REG_P1_Y: ctrl_y[1] = val;
      REG_P2_X: ctrl_x[2] = val;
      REG_P2_Y: ctrl_y[2] = val;
      REG_P3_X: ctrl_x[3] = val;
      REG_P3_Y: ctrl_y[3] = val;
      default: ;
    endcase
  endfunction

  function automatic void check_beat();
    splat_beat_t want;
    if (splat_q.size() == 0) begin
      $error("unexpected beat: pix_x %0d pix_y %0d green_add %0d last %0d",
             pix_x_i, pix_y_i, green_add_i, last_i);
      mismatches++;
    end else begin
      want = splat_q.pop_front();
      if (pix_x_i !== want.x) begin
        $error("pix_x: expected %0d, got %0d", want.x, pix_x_i);
        mismatches++;
      end
      if (pix_y_i !== want.y) begin
        $error("pix_y: expected %0d, got %0d", want.y, pix_y_i);
        mismatches++;
      end
      if (green_add_i !== want.w) begin
        $error("green_add: expected %0d, got %0d", want.w, green_add_i);
        mismatches++;
      end
      if (last_i !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last_i);
        mismatches++;
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_PTS; i++) begin
        ctrl_x[i] = '0;
        ctrl_y[i] = '0;
      end
      splat_q.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_beat();
      end
      if (in_valid_i && in_ready_i) begin
        predict_splat(t_step_i);
      end
      if (cfg_we_i) begin
        store_reg(cfg_reg_e'(cfg_idx_i), cfg_data_i);
      end
    end
    errors_o  <= mismatches;
    pending_o <= splat_q.size();
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import bdas_pkg::*;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 60;
  localparam int HOLD_CYCLES   = 300;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  cfg_reg_e           cfg_idx;
  logic [COORD_W-1:0] cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic [TW-1:0]      t_step;
  logic               out_valid;
  logic               out_ready;
  logic [COORD_W-1:0] pix_x;
  logic [COORD_W-1:0] pix_y;
  logic [W_W-1:0]     green_add;
  logic               last;
  int                 errors;
  int                 pending;
  int                 tx_max_gap = 12;
  int                 rx_max_gap = 12;
  int                 rx_hold = 0;
  int                 cycle_count = 0;

  bezier_decasteljau_antialias_splat_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .t_step_i    (t_step),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .pix_x_o     (pix_x),
    .pix_y_o     (pix_y),
    .green_add_o (green_add),
    .last_o      (last)
  );

  splat_check u_splat_check (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .t_step_i    (t_step),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .pix_x_i     (pix_x),
    .pix_y_i     (pix_y),
    .green_add_i (green_add),
    .last_i      (last),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls per beat, plus a long hold-off on request
  initial begin
    int stall;
    bit took;
    forever begin
      if (rx_hold > 0) begin
        out_ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      stall = (rx_max_gap == 0) ? 0 : $urandom_range(0, rx_max_gap);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = out_valid;
        @(posedge clk);
      end while (!took);
    end
  end

  task automatic write_reg(cfg_reg_e idx, logic [COORD_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic load_curve(logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
                            logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1,
                            logic [COORD_W-1:0] x2, logic [COORD_W-1:0] y2,
                            logic [COORD_W-1:0] x3, logic [COORD_W-1:0] y3);
    write_reg(REG_P0_X, x0);
    write_reg(REG_P0_Y, y0);
    write_reg(REG_P1_X, x1);
    write_reg(REG_P1_Y, y1);
    write_reg(REG_P2_X, x2);
    write_reg(REG_P2_Y, y2);
    write_reg(REG_P3_X, x3);
    write_reg(REG_P3_Y, y3);
    cfg_we <= 1'b0;
  endtask

  task automatic send_t(logic [TW-1:0] t);
    int gap;
    bit taken;
    gap = (tx_max_gap == 0) ? 0 : $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    t_step   <= t;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
  endtask

  // every expected beat back, then let zero-result items clear the pipe
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [COORD_W-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return COORD_W'(IMAGE_SIZE - 1);
      2: return COORD_W'($urandom_range(IMAGE_SIZE, 1023));
      default: return COORD_W'($urandom_range(0, IMAGE_SIZE - 1));
    endcase
  endfunction

  function automatic logic [TW-1:0] rand_t();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return T_ONE;
      2: return TW'($urandom_range(T_ONE + 1, (1 << TW) - 1));
      default: return TW'($urandom_range(0, T_ONE));
    endcase
  endfunction

  initial begin
    rst_n    <= 1'b0;
    cfg_we   <= 1'b0;
    cfg_idx  <= REG_P0_X;
    cfg_data <= '0;
    in_valid <= 1'b0;
    t_step   <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // control points straight out of reset
    send_t('0);
    send_t(T_ONE);
    drain();

    // corners of the image
    load_curve(0, 0, 699, 0, 0, 699, 699, 699);
    send_t('0);
    send_t(1);
    send_t(512);
    send_t(1023);
    send_t(T_ONE);
    send_t(1025);
    send_t(1536);
    send_t(2047);
    send_t(341);
    drain();

    // last row and column: the neighbours fall outside
    load_curve(699, 699, 699, 699, 699, 699, 699, 699);
    send_t('0);
    send_t(777);
    drain();

    // whole curve off the image
    load_curve(1023, 1023, 1023, 1023, 1023, 1023, 1023, 1023);
    send_t('0);
    send_t(T_ONE);
    drain();

    load_curve(0, 1023, 699, 0, 1023, 699, 699, 1023);
    send_t('0);
    send_t(T_ONE);
    send_t(512);
    send_t(2047);
    drain();

    // fractional point close to the far edge
    load_curve(698, 698, 699, 699, 699, 698, 698, 699);
    send_t(300);
    send_t(700);
    send_t(1000);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      load_curve(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord(), rand_coord());
      tx_max_gap = 12;
      rx_max_gap = 12;
      case (p)
        2: begin
          tx_max_gap = 0;
          rx_max_gap = 0;
        end
        4: rx_max_gap = 0;
        5: begin
          tx_max_gap = 0;
          rx_hold    = HOLD_CYCLES;
        end
        6: tx_max_gap = 0;
        default: ;
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_t(rand_t());
        if (i == PHASE_ITEMS / 2 && p != 5) begin
          drain();
        end
      end
      drain();
    end

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
